FILE: sv/mthd_pkg.sv
// Shared types and constants for the median threshold hit detector.
// Used by mthd_cell, mthd_hits and the top level; no dependencies.
`default_nettype none

package mthd_pkg;

    // Field widths
    localparam int MAX_CH    = 10;
    localparam int POW_W     = 32;
    localparam int FACT_W    = 12;
    localparam int CNT_W     = 16;
    localparam int CH_W      = 4;
    localparam int THR_W     = POW_W + FACT_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;
    localparam int RANK_W    = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_FACT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_ALL   = 2'd2;

    // Reset values and limits
    localparam logic [FACT_W-1:0] FACTOR_RESET = 12'd100;
    localparam logic [CNT_W-1:0]  COUNT_MAX    = 16'hFFFF;

    // Word handed from cell to cell along the chain
    typedef struct packed {
        logic [MAX_CH-1:0][POW_W-1:0] pow;
        logic                         lock;
        logic [POW_W-1:0]             median;
        logic [POW_W-1:0]             best_pow;
        logic [CH_W-1:0]              best_idx;
        logic                         found;
    } t_cell_bus;

    // Candidate word after the threshold multiply
    typedef struct packed {
        logic [THR_W-1:0] thr;
        logic [POW_W-1:0] best_pow;
        logic [CH_W-1:0]  best_idx;
        logic             found;
        logic             lock;
    } t_cand;

endpackage

`default_nettype wire

FILE: sv/mthd_cell.sv
// One channel cell of the ranking chain: finds this channel's stable rank,
// captures the median and updates the strongest unmasked candidate. Uses mthd_pkg.
`default_nettype none

module mthd_cell #(
    parameter int IDX    = 0,
    parameter int NUM_CH = 10,
    parameter int MRANK  = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load,
    input  wire logic                         i_valid,
    input  wire mthd_pkg::t_cell_bus          i_bus,
    input  wire logic [mthd_pkg::MAX_CH-1:0]  i_mask,
    output logic                              o_valid,
    output mthd_pkg::t_cell_bus               o_bus
);

    logic                          r_valid;
    mthd_pkg::t_cell_bus           r_bus;
    mthd_pkg::t_cell_bus           n_bus;
    logic [mthd_pkg::RANK_W-1:0]   rank;
    logic [mthd_pkg::POW_W-1:0]    own;

    // Count channels that sort below this one
    always_comb begin
        own  = i_bus.pow[IDX];
        rank = '0;
        for (int j = 0; j < NUM_CH; j++) begin
            if ((i_bus.pow[j] < own) || ((i_bus.pow[j] == own) && (j < IDX))) begin
                rank = rank + mthd_pkg::RANK_W'(1);
            end
        end
    end

    // Capture median and advance the candidate
    always_comb begin
        n_bus = i_bus;
        if (rank == mthd_pkg::RANK_W'(MRANK)) begin
            n_bus.median = own;
        end
        if (!i_mask[IDX] && (!i_bus.found || (own >= i_bus.best_pow))) begin
            n_bus.best_pow = own;
            n_bus.best_idx = mthd_pkg::CH_W'(IDX);
            n_bus.found    = 1'b1;
        end
    end

    // Clear valid under reset, load it with the word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    // Hold the word until the next cell is free
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bus <= n_bus;
        end
    end

    assign o_valid = r_valid;
    assign o_bus   = r_bus;

endmodule

`default_nettype wire

FILE: sv/mthd_hits.sv
// Hit decision, saturating per-channel hit counters and the output register.
// Uses mthd_pkg.
`default_nettype none

module mthd_hits #(
    parameter int NUM_CH = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire mthd_pkg::t_cand               i_cand,
    input  wire logic                          i_ignore_all,
    input  wire logic                          i_out_ready,
    output logic                               o_free,
    output logic                               o_out_valid,
    output logic                               o_out_hit,
    output logic [mthd_pkg::CH_W-1:0]          o_out_ch,
    output logic [mthd_pkg::CNT_W-1:0]         o_out_cnt
);

    localparam int IW = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;

    logic [NUM_CH-1:0][mthd_pkg::CNT_W-1:0] r_hits;
    logic [mthd_pkg::CH_W-1:0]              r_last;
    logic [mthd_pkg::CNT_W-1:0]             r_last_cnt;
    logic                                   r_out_valid;
    logic                                   r_out_hit;
    logic [mthd_pkg::CH_W-1:0]              r_out_ch;
    logic [mthd_pkg::CNT_W-1:0]             r_out_cnt;

    logic                                   take;
    logic                                   hit;
    logic [IW-1:0]                          sel;
    logic [mthd_pkg::CNT_W-1:0]             cur;
    logic [mthd_pkg::CNT_W-1:0]             n_cnt;

    assign o_free = !r_out_valid || i_out_ready;
    assign take   = i_valid && o_free;
    assign sel    = i_cand.best_idx[IW-1:0];

    // Decide hit and form the saturating increment
    always_comb begin
        hit = i_cand.found && !i_ignore_all && !i_cand.lock &&
              ({{(mthd_pkg::THR_W-mthd_pkg::POW_W){1'b0}}, i_cand.best_pow} > i_cand.thr);
        cur   = r_hits[sel];
        n_cnt = (cur == mthd_pkg::COUNT_MAX) ? cur : cur + mthd_pkg::CNT_W'(1);
    end

    // Update counters, the held channel and the output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits      <= '0;
            r_last      <= '0;
            r_last_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_free) begin
                r_out_valid <= i_valid;
            end
            if (take && hit) begin
                r_hits[sel] <= n_cnt;
                r_last      <= i_cand.best_idx;
                r_last_cnt  <= n_cnt;
            end
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_hit <= hit;
            r_out_ch  <= hit ? i_cand.best_idx : r_last;
            r_out_cnt <= hit ? n_cnt : r_last_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_hit   = r_out_hit;
    assign o_out_ch    = r_out_ch;
    assign o_out_cnt   = r_out_cnt;

endmodule

`default_nettype wire

FILE: sv/median_threshold_hit_detector_unit.sv
// Median threshold hit detector: a usage summary.
// Input stream s_axis: one word per set of channel powers (power_0 in the
// lowest 32 bits), tuser carries the lockout flag. Output stream m_axis: one
// result word per input word, tuser carries hit, tdata carries the channel of
// the most recent hit and that channel's saturating hit count.
// Configuration: a separate write channel (index, data), always ready; write
// only while no word is in flight.
// An accepted word passes through the register of each channel cell of the
// ranking chain, then the threshold multiply register, then the hit decision
// and counter update into the output register.
// Throughput is one word per cycle while the output is not held back; each
// stage moves on its own, so bubbles collapse and the chain keeps filling while the output waits.
// When m_axis_tready is low the output word holds and the chain fills up;
// s_axis_tready drops once every stage holds a word.
// Reset clears all hit counters, the held channel, the pipeline and the
// configuration registers (mask 0, factor 100, hits enabled).
// Depends on mthd_pkg, mthd_cell and mthd_hits.
`default_nettype none

module median_threshold_hit_detector_unit #(
    parameter int NUM_CHANNELS = 10,
    parameter int MEDIAN_RANK  = 4
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // power_0 .. power_9, 32 bits each from the lowest bit up
    input  wire logic [mthd_pkg::MAX_CH*mthd_pkg::POW_W-1:0] s_axis_tdata,
    // lockout_active
    input  wire logic                               s_axis_tuser,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // hit_channel [3:0], hit_count [19:4], zero fill [23:20]
    output logic [23:0]                             m_axis_tdata,
    // hit
    output logic                                    m_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [mthd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [mthd_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    localparam int MRANK = (MEDIAN_RANK >= NUM_CHANNELS) ? NUM_CHANNELS - 1 : MEDIAN_RANK;

    logic [mthd_pkg::MAX_CH-1:0]  r_ignore_mask;
    logic [mthd_pkg::FACT_W-1:0]  r_factor;
    logic                         r_ignore_all;

    mthd_pkg::t_cell_bus          bus  [NUM_CHANNELS+1];
    logic [NUM_CHANNELS:0]        vld;
    logic [NUM_CHANNELS:0]        free;

    logic                         r_m_valid;
    mthd_pkg::t_cand              r_cand;
    logic                         free_m;
    logic                         free_out;

    logic                         out_hit;
    logic [mthd_pkg::CH_W-1:0]    out_ch;
    logic [mthd_pkg::CNT_W-1:0]   out_cnt;

    // Write configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ignore_mask <= '0;
            r_factor      <= mthd_pkg::FACTOR_RESET;
            r_ignore_all  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mthd_pkg::REG_IGNORE_MASK: r_ignore_mask <= i_cfg_data[mthd_pkg::MAX_CH-1:0];
                mthd_pkg::REG_THRESH_FACT: r_factor      <= i_cfg_data[mthd_pkg::FACT_W-1:0];
                mthd_pkg::REG_IGNORE_ALL:  r_ignore_all  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Form the chain's entry word
    always_comb begin
        bus[0]          = '0;
        bus[0].pow      = s_axis_tdata;
        bus[0].lock     = s_axis_tuser;
    end

    assign vld[0]             = s_axis_tvalid;
    assign free[NUM_CHANNELS] = free_m;
    assign s_axis_tready      = free[0];

    // Build the row of channel cells
    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_cell
        logic cell_valid;

        mthd_cell #(
            .IDX    (g),
            .NUM_CH (NUM_CHANNELS),
            .MRANK  (MRANK)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (free[g]),
            .i_valid (vld[g]),
            .i_bus   (bus[g]),
            .i_mask  (r_ignore_mask),
            .o_valid (cell_valid),
            .o_bus   (bus[g+1])
        );

        assign vld[g+1] = cell_valid;
        assign free[g]  = !cell_valid || free[g+1];
    end

    // Multiply the median by the factor
    assign free_m = !r_m_valid || free_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (free_m) begin
            r_m_valid <= vld[NUM_CHANNELS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (free_m) begin
            r_cand.thr      <= {{mthd_pkg::FACT_W{1'b0}}, bus[NUM_CHANNELS].median} *
                               {{mthd_pkg::POW_W{1'b0}}, r_factor};
            r_cand.best_pow <= bus[NUM_CHANNELS].best_pow;
            r_cand.best_idx <= bus[NUM_CHANNELS].best_idx;
            r_cand.found    <= bus[NUM_CHANNELS].found;
            r_cand.lock     <= bus[NUM_CHANNELS].lock;
        end
    end

    // Decide hits and count them
    mthd_hits #(
        .NUM_CH (NUM_CHANNELS)
    ) u_hits (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_m_valid),
        .i_cand       (r_cand),
        .i_ignore_all (r_ignore_all),
        .i_out_ready  (m_axis_tready),
        .o_free       (free_out),
        .o_out_valid  (m_axis_tvalid),
        .o_out_hit    (out_hit),
        .o_out_ch     (out_ch),
        .o_out_cnt    (out_cnt)
    );

    assign m_axis_tuser = out_hit;
    assign m_axis_tdata = {4'b0000, out_cnt, out_ch};

endmodule

`default_nettype wire

FILE: tb/median_threshold_hit_detector_unit_tb.sv
// Self-checking testbench for median_threshold_hit_detector_unit: directed table, then random
// power sets under several idle and stall patterns, each result checked against a table entry or a local model.
// Depends on mthd_pkg and the RTL of the detector; reads no files.
`default_nettype none

module median_threshold_hit_detector_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mthd_pkg::*;

    localparam int N_CH        = 10;
    localparam int MED_RANK    = 4;
    localparam int SETTLE      = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 200;
    localparam int SAT_REPS    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef logic [MAX_CH-1:0][POW_W-1:0] t_powers;

    typedef struct packed {
        logic             hit;
        logic [CH_W-1:0]  ch;
        logic [CNT_W-1:0] cnt;
    } t_hit_report;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] val;
        t_powers              pw;
        logic                 lock;
        int                   reps;
        bit                   typed;
        t_hit_report          want;
    } t_row;

    // Ports
    logic                         i_clk;
    logic                         i_rst_n;
    logic [MAX_CH*POW_W-1:0]      s_axis_tdata;
    logic                         s_axis_tuser;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [23:0]                  m_axis_tdata;
    logic                         m_axis_tuser;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [CFG_DAT_W-1:0]         i_cfg_data;

    // Model state and register copies
    logic [CNT_W-1:0]  hit_tally [N_CH];
    logic [CH_W-1:0]   held_ch;
    logic [MAX_CH-1:0] cfg_mask;
    logic [FACT_W-1:0] cfg_factor;
    logic              cfg_no_hits;

    t_hit_report hit_queue [$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          rx_hold_id  = 0;
    int          rx_hold_seen = 0;
    int          rx_hold_left = 0;

    median_threshold_hit_detector_unit #(
        .NUM_CHANNELS (N_CH),
        .MEDIAN_RANK  (MED_RANK)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Power at the median rank; ties rank the lower channel first
    function automatic logic [POW_W-1:0] median_power(t_powers pw);
        int               r;
        logic [POW_W-1:0] m;
        m = '0;
        for (int i = 0; i < N_CH; i++) begin
            r = 0;
            for (int j = 0; j < N_CH; j++)
                if (pw[j] < pw[i] || (pw[j] == pw[i] && j < i)) r++;
            if (r == MED_RANK) m = pw[i];
        end
        return m;
    endfunction

    // Decide the hit for one power set and advance the counters
    function automatic t_hit_report detect_hit(t_powers pw, logic lock);
        logic [THR_W-1:0] thr;
        int               best;
        bit               found;
        t_hit_report      r;
        thr   = median_power(pw) * cfg_factor;
        best  = 0;
        found = 1'b0;
        for (int i = 0; i < N_CH; i++) begin
            if (!cfg_mask[i] && (!found || pw[i] >= pw[best])) begin
                best  = i;
                found = 1'b1;
            end
        end
        r.hit = found && !cfg_no_hits && !lock && (THR_W'(pw[best]) > thr);
        if (r.hit) begin
            if (hit_tally[best] != COUNT_MAX) hit_tally[best]++;
            held_ch = CH_W'(best);
        end
        r.ch  = held_ch;
        r.cnt = hit_tally[held_ch];
        return r;
    endfunction

    function automatic t_powers one_hot_power(int ch, logic [POW_W-1:0] v);
        t_powers pw;
        pw     = '0;
        pw[ch] = v;
        return pw;
    endfunction

    function automatic t_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        t_row r;
        r      = '{kind: ROW_CFG, default: '0};
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    function automatic t_row item_row(t_powers pw, logic lock, int reps, bit typed,
                                      t_hit_report want);
        t_row r;
        r       = '{kind: ROW_ITEM, default: '0};
        r.kind  = ROW_ITEM;
        r.pw    = pw;
        r.lock  = lock;
        r.reps  = reps;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // Offer one word, wait for acceptance, record its expected result
    task automatic send_item(t_powers pw, logic lock, bit typed, t_hit_report want);
        t_hit_report model;
        s_axis_tdata  <= pw;
        s_axis_tuser  <= lock;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        model = detect_hit(pw, lock);
        hit_queue.push_back(typed ? want : model);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    // Hold off input until every expected word has come back
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (hit_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_IGNORE_MASK: cfg_mask    = val[MAX_CH-1:0];
            REG_THRESH_FACT: cfg_factor  = val[FACT_W-1:0];
            REG_IGNORE_ALL:  cfg_no_hits = val[0];
            default: ;
        endcase
        // Wait with valid low before the next write
        @(posedge i_clk);
    endtask

    // Result check and receiver backpressure
    always @(posedge i_clk) begin
        t_hit_report got;
        t_hit_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[19:4]};
            if (hit_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: hit %0d ch %0d cnt %0d",
                             got.hit, got.ch, got.cnt);
            end else begin
                want = hit_queue.pop_front();
                if (got.hit != want.hit || got.ch != want.ch || got.cnt != want.cnt) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected hit %0d ch %0d cnt %0d, got %0d %0d %0d",
                                 want.hit, want.ch, want.cnt, got.hit, got.ch, got.cnt);
                end
            end
        end
        if (rx_hold_id != rx_hold_seen) begin
            rx_hold_seen = rx_hold_id;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_row             rows [$];
        t_row             row;
        t_powers          pw;
        logic             lock;
        int               c;
        int               mode;
        logic [THR_W-1:0] thr;

        i_rst_n       <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tvalid <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_IGNORE_MASK;
        i_cfg_data    <= '0;
        for (int i = 0; i < N_CH; i++) hit_tally[i] = '0;
        held_ch     = '0;
        cfg_mask    = '0;
        cfg_factor  = FACTOR_RESET;
        cfg_no_hits = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: extremes, ties, lockout, masking, threshold edges, repeated hits
        rows.push_back(item_row('0, 1'b0, 1, 1'b1, '{1'b0, 4'd0, 16'd0}));
        rows.push_back(item_row('1, 1'b0, 1, 1'b1, '{1'b0, 4'd0, 16'd0}));
        rows.push_back(item_row(one_hot_power(5, '1), 1'b0, 1, 1'b1, '{1'b1, 4'd5, 16'd1}));
        rows.push_back(item_row(one_hot_power(5, '1), 1'b1, 1, 1'b1, '{1'b0, 4'd5, 16'd1}));
        rows.push_back(item_row(one_hot_power(0, 1), 1'b0, 1, 1'b1, '{1'b1, 4'd0, 16'd1}));
        rows.push_back(item_row(one_hot_power(3, 1000) | one_hot_power(7, 1000), 1'b0, 1, 1'b1,
                                '{1'b1, 4'd7, 16'd1}));
        rows.push_back(cfg_row(REG_THRESH_FACT, 12'd0));
        rows.push_back(item_row({MAX_CH{32'd5}}, 1'b0, 1, 1'b0, '0));
        rows.push_back(cfg_row(REG_THRESH_FACT, 12'd4095));
        pw = {MAX_CH{32'd1}};
        pw[6] = 32'd4095;
        rows.push_back(item_row(pw, 1'b0, 1, 1'b0, '0));
        pw[6] = 32'd4096;
        rows.push_back(item_row(pw, 1'b0, 1, 1'b0, '0));
        rows.push_back(cfg_row(REG_IGNORE_MASK, 12'h3FF));
        rows.push_back(item_row(one_hot_power(2, '1), 1'b0, 1, 1'b0, '0));
        rows.push_back(cfg_row(REG_IGNORE_MASK, 12'h200));
        rows.push_back(item_row(one_hot_power(9, '1) | one_hot_power(8, 50), 1'b0, 1, 1'b0, '0));
        rows.push_back(cfg_row(REG_IGNORE_ALL, 12'd1));
        rows.push_back(item_row(one_hot_power(4, '1), 1'b0, 1, 1'b0, '0));
        rows.push_back(cfg_row(REG_UNUSED, 12'hFFF));
        rows.push_back(item_row(one_hot_power(4, '1), 1'b0, 1, 1'b0, '0));
        rows.push_back(cfg_row(REG_IGNORE_ALL, 12'd0));
        rows.push_back(cfg_row(REG_IGNORE_MASK, 12'd0));
        rows.push_back(cfg_row(REG_THRESH_FACT, 12'd100));
        for (int i = 0; i < N_CH; i++) pw[i] = POW_W'(i + 1);
        rows.push_back(item_row(pw, 1'b0, 1, 1'b0, '0));
        rows.push_back(item_row(one_hot_power(1, '1), 1'b0, SAT_REPS, 1'b0, '0));
        rows.push_back(item_row(one_hot_power(1, '1), 1'b0, 1, 1'b0, '0));

        foreach (rows[r]) begin
            row = rows[r];
            if (row.kind == ROW_CFG) begin
                wait_drain();
                write_reg(row.idx, row.val);
            end else begin
                for (int k = 0; k < row.reps; k++) send_item(row.pw, row.lock, row.typed, row.want);
            end
        end

        // Random phases: new registers each phase, cycle through idle patterns
        for (int p = 0; p < N_PHASES; p++) begin
            wait_drain();
            write_reg(REG_IGNORE_MASK,
                      ($urandom_range(2) == 0) ? 12'd0 : CFG_DAT_W'($urandom_range(1023)));
            case ($urandom_range(4))
                0:       write_reg(REG_THRESH_FACT, 12'd0);
                1:       write_reg(REG_THRESH_FACT, 12'd4095);
                2:       write_reg(REG_THRESH_FACT, CFG_DAT_W'($urandom_range(1, 16)));
                default: write_reg(REG_THRESH_FACT, CFG_DAT_W'($urandom_range(4095)));
            endcase
            write_reg(REG_IGNORE_ALL, ($urandom_range(5) == 0) ? 12'd1 : 12'd0);
            write_reg(REG_UNUSED, CFG_DAT_W'($urandom_range(4095)));

            tx_idle_pct  = (p % 4 == 1) ? 50 : (p % 4 == 3) ? 23 : 0;
            rx_stall_pct = (p % 4 == 2) ? 50 : (p % 4 == 3) ? 23 : 0;
            // Long receiver hold while the sender keeps pushing
            if (p == 2) rx_hold_id++;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Pause input mid-phase until the pipeline empties
                if (p == 1 && k == PHASE_ITEMS / 2) wait_drain();
                c    = $urandom_range(N_CH - 1);
                mode = $urandom_range(9);
                for (int i = 0; i < N_CH; i++) pw[i] = $urandom_range(1000);
                case (mode)
                    0, 1, 2, 3: pw[c] = $urandom();
                    4: begin
                        // Spike just around the threshold
                        pw[c] = '1;
                        thr   = median_power(pw) * cfg_factor;
                        pw[c] = POW_W'(thr) + POW_W'($urandom_range(2)) - 1;
                    end
                    5, 6: for (int i = 0; i < N_CH; i++) pw[i] = $urandom();
                    7:    for (int i = 0; i < N_CH; i++) pw[i] = $urandom_range(3);
                    8: begin
                        for (int i = 0; i < N_CH; i++)
                            case ($urandom_range(2))
                                0:       pw[i] = '0;
                                1:       pw[i] = '1;
                                default: pw[i] = 32'h8000_0000;
                            endcase
                    end
                    default: pw = {MAX_CH{32'($urandom())}};
                endcase
                lock = ($urandom_range(7) == 0);
                send_item(pw, lock, 1'b0, '0);
            end
        end

        wait_drain();
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
